// ----- rtl/core/stdp_pkg.sv -----
`default_nettype none
package stdp_pkg;

    // exp(-x) lookup
    localparam int EXP_TABLE_DEPTH = 256;
    localparam int EXP_IDX_W = $clog2(EXP_TABLE_DEPTH);
    localparam logic [63:0] LN2_Q32 = 64'd2977044472;
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [22:0] EXP_X_CAP = 23'(64 << 16);
    localparam logic [6:0] EXP_N_LIMIT = 7'd17;
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    localparam logic [23:0] MAX24 = 24'hFFFFFF;

    // reset values
    localparam logic [15:0] RATE_RESET = 16'd655;
    localparam logic [15:0] DECAY_RESET = 16'd10;
    localparam logic [15:0] LEN_RESET = 16'd65535;
    localparam logic [23:0] PERM_RESET = 24'h010000;
    localparam logic [31:0] LAST_POST_RESET = 32'd1;

    // lag to exponent: k = lag / 10 (pre) or lag / 20 (post), via *205 and a shift.
    // Any k of 12 or more gives exp = 0, so k saturates there.
    localparam logic [3:0] K_SAT = 4'd12;
    localparam logic [31:0] PRE_LAG_LIMIT = 32'd120;
    localparam logic [31:0] POST_LAG_LIMIT = 32'd240;
    localparam logic [7:0] RECIP_DIV = 8'd205;

    // divider: 24 quotient bits, 4 per step
    localparam int DIV_BITS = 4;
    localparam int DIV_STEPS = 6;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // commands
    localparam logic [1:0] CMD_PRE = 2'd0;
    localparam logic [1:0] CMD_POST = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // register indexes
    localparam logic [1:0] REG_LEARNING_RATE = 2'd0;
    localparam logic [1:0] REG_DECAY_TIME = 2'd1;
    localparam logic [1:0] REG_LENGTH_FACTOR = 2'd2;

    typedef logic [16:0] t_exp_rom [EXP_TABLE_DEPTH];

    // 2^(-i/DEPTH) in Q16, Taylor series of exp(-i*ln2/DEPTH) in Q32
    function automatic t_exp_rom build_exp_rom();
        t_exp_rom rom;
        logic [63:0] a;
        logic [63:0] term;
        logic [63:0] sum;
        for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
            a = (64'(i) * LN2_Q32 + 64'(EXP_TABLE_DEPTH / 2)) / 64'(EXP_TABLE_DEPTH);
            term = 64'd1 << 32;
            sum = term;
            for (int k = 1; k <= 16; k++) begin
                term = ((term * a) >> 32) / 64'(k);
                if ((k & 1) != 0) begin
                    sum = (sum >= term) ? sum - term : 64'd0;
                end else begin
                    sum = sum + term;
                end
            end
            rom[i] = 17'((sum + 64'd32768) >> 16);
        end
        return rom;
    endfunction

    localparam t_exp_rom EXP_ROM = build_exp_rom();

    // microcode
    typedef enum logic [3:0] {
        OP_NOP,
        OP_DT_PRE,
        OP_DT_POST,
        OP_DT_READ,
        OP_K_PRE,
        OP_K_POST,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_EXP_Y,
        OP_EXP_E,
        OP_APPLY,
        OP_RELEASE,
        OP_VOLT,
        OP_DONE
    } t_alu_op;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_RATE_PERM,
        MUL_ACC_E,
        MUL_CLEFT_BOUND,
        MUL_ACC_PERM,
        MUL_ACC_LEN
    } t_mul_sel;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_ALWAYS,
        JMP_DT_NONPOS,
        JMP_DIV_MORE
    } t_jump;

    typedef logic [4:0] t_upc;

    typedef struct packed {
        t_alu_op  op;
        t_mul_sel mul;
        t_jump    jmp;
        t_upc     target;
    } t_uword;

    typedef struct packed {
        logic       start;
        logic [1:0] cmd;
        logic       dt_nonpos;
        logic       div_last;
        logic       out_free;
    } t_seq_status;

    localparam t_upc UA_PRE = 5'd0;
    localparam t_upc UA_POST = 5'd2;
    localparam t_upc UA_PLAS = 5'd4;
    localparam t_upc UA_READ = 5'd8;
    localparam t_upc UA_DIV = 5'd10;
    localparam t_upc UA_DONE = 5'd17;

    function automatic t_uword uw(t_alu_op op, t_mul_sel mul, t_jump jmp, t_upc target);
        t_uword w;
        w.op = op;
        w.mul = mul;
        w.jmp = jmp;
        w.target = target;
        return w;
    endfunction

    localparam t_uword UW_IDLE = '{op: OP_NOP, mul: MUL_NONE, jmp: JMP_NEXT, target: 5'd0};

    function automatic t_uword ucode(t_upc pc);
        t_uword w;
        case (pc)
            // pre spike
            5'd0:  w = uw(OP_DT_PRE,   MUL_NONE,        JMP_NEXT,      UA_DONE);
            5'd1:  w = uw(OP_K_PRE,    MUL_NONE,        JMP_ALWAYS,    UA_PLAS);
            // post spike
            5'd2:  w = uw(OP_DT_POST,  MUL_NONE,        JMP_NEXT,      UA_DONE);
            5'd3:  w = uw(OP_K_POST,   MUL_NONE,        JMP_NEXT,      UA_DONE);
            // shared plasticity update
            5'd4:  w = uw(OP_EXP_Y,    MUL_NONE,        JMP_NEXT,      UA_DONE);
            5'd5:  w = uw(OP_EXP_E,    MUL_RATE_PERM,   JMP_NEXT,      UA_DONE);
            5'd6:  w = uw(OP_NOP,      MUL_ACC_E,       JMP_NEXT,      UA_DONE);
            5'd7:  w = uw(OP_APPLY,    MUL_NONE,        JMP_ALWAYS,    UA_DONE);
            // read
            5'd8:  w = uw(OP_DT_READ,  MUL_NONE,        JMP_NEXT,      UA_DONE);
            5'd9:  w = uw(OP_DIV_INIT, MUL_NONE,        JMP_DT_NONPOS, UA_DONE);
            5'd10: w = uw(OP_DIV_STEP, MUL_NONE,        JMP_DIV_MORE,  UA_DIV);
            5'd11: w = uw(OP_EXP_Y,    MUL_NONE,        JMP_NEXT,      UA_DONE);
            5'd12: w = uw(OP_EXP_E,    MUL_NONE,        JMP_NEXT,      UA_DONE);
            5'd13: w = uw(OP_NOP,      MUL_CLEFT_BOUND, JMP_NEXT,      UA_DONE);
            5'd14: w = uw(OP_RELEASE,  MUL_ACC_PERM,    JMP_NEXT,      UA_DONE);
            5'd15: w = uw(OP_NOP,      MUL_ACC_LEN,     JMP_NEXT,      UA_DONE);
            5'd16: w = uw(OP_VOLT,     MUL_NONE,        JMP_NEXT,      UA_DONE);
            default: w = uw(OP_DONE,   MUL_NONE,        JMP_NEXT,      UA_DONE);
        endcase
        return w;
    endfunction

    function automatic t_upc entry_addr(logic [1:0] cmd);
        t_upc a;
        case (cmd)
            CMD_PRE:  a = UA_PRE;
            CMD_POST: a = UA_POST;
            CMD_READ: a = UA_READ;
            default:  a = UA_DONE;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/stdp_ifs.sv -----
`default_nettype none
interface stdp_evt_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] time_ms;
    logic [23:0] transmitter_amount;

    modport source(output valid, command, time_ms, transmitter_amount, input ready);
    modport sink(input valid, command, time_ms, transmitter_amount, output ready);
endinterface

interface stdp_res_if;
    logic        valid;
    logic        ready;
    logic [23:0] voltage;
    logic [23:0] weight;

    modport source(output valid, voltage, weight, input ready);
    modport sink(input valid, voltage, weight, output ready);
endinterface

interface stdp_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/stdp_useq.sv -----
`default_nettype none
module stdp_useq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  stdp_pkg::t_seq_status i_status,
    output stdp_pkg::t_uword     o_ctrl,
    output logic                 o_busy
);

    stdp_pkg::t_upc   r_pc;
    stdp_pkg::t_upc   n_pc;
    logic             r_busy;
    logic             n_busy;
    stdp_pkg::t_uword word;
    logic             take;

    assign word = stdp_pkg::ucode(r_pc);

    always_comb begin
        case (word.jmp)
            stdp_pkg::JMP_ALWAYS:    take = 1'b1;
            stdp_pkg::JMP_DT_NONPOS: take = i_status.dt_nonpos;
            stdp_pkg::JMP_DIV_MORE:  take = !i_status.div_last;
            default:                 take = 1'b0;
        endcase
    end

    always_comb begin
        n_pc = r_pc;
        n_busy = r_busy;
        if (!r_busy) begin
            if (i_status.start) begin
                n_pc = stdp_pkg::entry_addr(i_status.cmd);
                n_busy = 1'b1;
            end
        end else if (word.op == stdp_pkg::OP_DONE) begin
            // hold here until the output register can take the result
            if (i_status.out_free) begin
                n_busy = 1'b0;
            end
        end else begin
            n_pc = take ? word.target : r_pc + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0;
            r_busy <= 1'b0;
        end else begin
            r_pc <= n_pc;
            r_busy <= n_busy;
        end
    end

    assign o_ctrl = r_busy ? word : stdp_pkg::UW_IDLE;
    assign o_busy = r_busy;

endmodule
`default_nettype wire

// ----- rtl/core/stdp_synapse_update.sv -----
`default_nettype none
// Each command runs its microcode program from the accepting edge to result valid;
// a read with dt <= 0 jumps straight to done, as does the unused command.
// One transaction at a time; the next is accepted the cycle after the result is
// registered; a finished program waits in done while the output register is full.
// A read runs the quotient divider, 4 bits per microcode step over 6 steps.
// Synchronous active-low reset restores registers and synapse state, output empty.
module stdp_synapse_update (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stdp_evt_if.sink    i_evt,
    stdp_cfg_if.sink    i_cfg,
    stdp_res_if.source  o_res
);

    // configuration and synapse state
    logic [15:0] r_rate;
    logic [15:0] r_decay;
    logic [15:0] r_len;
    logic [23:0] r_cleft;
    logic [23:0] r_perm;
    logic [31:0] r_last_pre;
    logic [31:0] r_last_post;

    // datapath
    logic [1:0]  r_cmd;
    logic [31:0] r_now;
    logic [23:0] r_amount;
    logic [31:0] r_dt;
    logic [23:0] r_x;
    logic [15:0] r_rem;
    logic        r_div_sat;
    logic [stdp_pkg::DIV_CNT_W-1:0] r_div_cnt;
    logic [22:0] r_y;
    logic [16:0] r_e;
    logic [31:0] r_acc;
    logic [23:0] r_volt;

    // output register
    logic        r_out_valid;
    logic [23:0] r_out_voltage;
    logic [23:0] r_out_weight;

    logic                  seq_busy;
    stdp_pkg::t_uword      ctrl;
    stdp_pkg::t_seq_status status;
    logic                  evt_accept;
    logic                  out_free;
    logic [15:0]           tc;

    assign i_evt.ready = !seq_busy;
    assign i_cfg.ready = 1'b1;
    assign evt_accept = i_evt.valid && i_evt.ready;
    assign out_free = !r_out_valid || o_res.ready;
    assign tc = (r_decay == 16'd0) ? 16'd1 : r_decay;

    assign status.start = evt_accept;
    assign status.cmd = i_evt.command;
    assign status.dt_nonpos = (r_dt == 32'd0) || r_dt[31];
    assign status.div_last = (r_div_cnt == stdp_pkg::DIV_CNT_W'(stdp_pkg::DIV_STEPS - 1));
    assign status.out_free = out_free;

    stdp_useq u_useq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl),
        .o_busy   (seq_busy)
    );

    // exponent k from the lag, saturated at K_SAT
    logic [31:0] lag_pre;
    logic [14:0] k_pre_prod;
    logic [15:0] k_post_prod;
    logic [3:0]  k_pre;
    logic [3:0]  k_post;

    assign lag_pre = 32'd0 - r_dt;
    assign k_pre_prod = 15'(r_dt[6:0] == 7'd0 ? 15'd0 : 15'(lag_pre[6:0]) * 15'(stdp_pkg::RECIP_DIV));
    assign k_post_prod = 16'(r_dt[7:0]) * 16'(stdp_pkg::RECIP_DIV);

    always_comb begin
        if (!((r_dt == 32'd0) || r_dt[31])) begin
            k_pre = 4'd0;
        end else if (lag_pre >= stdp_pkg::PRE_LAG_LIMIT) begin
            k_pre = stdp_pkg::K_SAT;
        end else begin
            k_pre = k_pre_prod[14:11];
        end
        if (r_dt[31]) begin
            k_post = 4'd0;
        end else if (r_dt >= stdp_pkg::POST_LAG_LIMIT) begin
            k_post = stdp_pkg::K_SAT;
        end else begin
            k_post = k_post_prod[15:12];
        end
    end

    // restoring divider, DIV_BITS quotient bits per step; r_x shifts dividend out, quotient in
    logic [15:0] div_rem;
    logic [23:0] div_q;
    logic [16:0] div_trial;

    always_comb begin
        div_rem = r_rem;
        div_q = r_x;
        div_trial = '0;
        for (int j = 0; j < stdp_pkg::DIV_BITS; j++) begin
            div_trial = {div_rem, div_q[23]};
            div_q = {div_q[22:0], 1'b0};
            if (div_trial >= {1'b0, tc}) begin
                div_trial = div_trial - {1'b0, tc};
                div_q[0] = 1'b1;
            end
            div_rem = div_trial[15:0];
        end
    end

    // exp(-x) = 2^(-y), y = x * log2(e)
    logic [22:0] x_eff;
    logic [40:0] y_sum;
    logic [31:0] idx_prod;
    logic [stdp_pkg::EXP_IDX_W-1:0] exp_idx;
    logic [16:0] rom_val;
    logic [16:0] e_next;

    assign x_eff = (r_div_sat || (r_x > {1'b0, stdp_pkg::EXP_X_CAP})) ?
                   stdp_pkg::EXP_X_CAP : r_x[22:0];
    assign y_sum = 41'(x_eff) * 41'(stdp_pkg::LOG2E_Q16) + 41'd32768;
    assign idx_prod = 32'(r_y[15:0]) * 32'(stdp_pkg::EXP_TABLE_DEPTH);
    assign exp_idx = idx_prod[16 +: stdp_pkg::EXP_IDX_W];
    assign rom_val = stdp_pkg::EXP_ROM[exp_idx];
    assign e_next = (r_y[22:16] >= stdp_pkg::EXP_N_LIMIT) ? 17'd0 : rom_val >> r_y[20:16];

    // shared multiplier, Q16 products truncated
    logic [31:0] mul_a;
    logic [23:0] mul_b;
    logic [55:0] mul_prod;
    logic [16:0] bound;

    assign bound = stdp_pkg::ONE_Q16 - r_e;

    always_comb begin
        case (ctrl.mul)
            stdp_pkg::MUL_RATE_PERM: begin
                mul_a = 32'(r_rate);
                mul_b = r_perm;
            end
            stdp_pkg::MUL_ACC_E: begin
                mul_a = r_acc;
                mul_b = 24'(r_e);
            end
            stdp_pkg::MUL_CLEFT_BOUND: begin
                mul_a = 32'(r_cleft);
                mul_b = 24'(bound);
            end
            stdp_pkg::MUL_ACC_PERM: begin
                mul_a = r_acc;
                mul_b = r_perm;
            end
            stdp_pkg::MUL_ACC_LEN: begin
                mul_a = r_acc;
                mul_b = 24'(r_len);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_prod = 56'(mul_a) * 56'(mul_b);

    logic [24:0] cleft_sum;
    logic [24:0] perm_sum;

    assign cleft_sum = {1'b0, r_cleft} + {1'b0, r_amount};
    assign perm_sum = {1'b0, r_perm} + {1'b0, r_acc[23:0]};

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= stdp_pkg::RATE_RESET;
            r_decay <= stdp_pkg::DECAY_RESET;
            r_len <= stdp_pkg::LEN_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                stdp_pkg::REG_LEARNING_RATE: r_rate <= i_cfg.data;
                stdp_pkg::REG_DECAY_TIME:    r_decay <= i_cfg.data;
                stdp_pkg::REG_LENGTH_FACTOR: r_len <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // synapse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cleft <= '0;
            r_perm <= stdp_pkg::PERM_RESET;
            r_last_pre <= '0;
            r_last_post <= stdp_pkg::LAST_POST_RESET;
        end else begin
            case (ctrl.op)
                stdp_pkg::OP_DT_PRE: begin
                    r_last_pre <= r_now;
                    r_cleft <= cleft_sum[24] ? stdp_pkg::MAX24 : cleft_sum[23:0];
                end
                stdp_pkg::OP_DT_POST: begin
                    r_last_post <= r_now;
                end
                stdp_pkg::OP_APPLY: begin
                    if (r_cmd == stdp_pkg::CMD_PRE) begin
                        r_perm <= (r_perm > r_acc[23:0]) ? r_perm - r_acc[23:0] : 24'd0;
                    end else begin
                        r_perm <= perm_sum[24] ? stdp_pkg::MAX24 : perm_sum[23:0];
                    end
                end
                stdp_pkg::OP_RELEASE: begin
                    // released amount never exceeds the cleft level
                    r_cleft <= r_cleft - r_acc[23:0];
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (evt_accept) begin
            r_cmd <= i_evt.command;
            r_now <= i_evt.time_ms;
            r_amount <= i_evt.transmitter_amount;
            r_volt <= '0;
        end
        if (ctrl.mul != stdp_pkg::MUL_NONE) begin
            r_acc <= mul_prod[47:16];
        end
        case (ctrl.op)
            stdp_pkg::OP_DT_PRE: r_dt <= r_last_post - r_now;
            stdp_pkg::OP_DT_POST: r_dt <= r_now - r_last_pre;
            stdp_pkg::OP_DT_READ: r_dt <= r_now - r_last_pre;
            stdp_pkg::OP_K_PRE: begin
                r_x <= {4'd0, k_pre, 16'd0};
                r_div_sat <= 1'b0;
            end
            stdp_pkg::OP_K_POST: begin
                r_x <= {4'd0, k_post, 16'd0};
                r_div_sat <= 1'b0;
            end
            stdp_pkg::OP_DIV_INIT: begin
                // quotient >= 2^23 exceeds the exp cap anyway
                r_div_sat <= (r_dt[30:7] >= 24'(tc));
                r_rem <= r_dt[23:8];
                r_x <= {r_dt[7:0], 16'd0};
                r_div_cnt <= '0;
            end
            stdp_pkg::OP_DIV_STEP: begin
                r_rem <= div_rem;
                r_x <= div_q;
                r_div_cnt <= r_div_cnt + stdp_pkg::DIV_CNT_W'(1);
            end
            stdp_pkg::OP_EXP_Y: r_y <= y_sum[38:16];
            stdp_pkg::OP_EXP_E: r_e <= e_next;
            stdp_pkg::OP_VOLT: r_volt <= (r_acc > 32'(stdp_pkg::MAX24)) ?
                                         stdp_pkg::MAX24 : r_acc[23:0];
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.op == stdp_pkg::OP_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.op == stdp_pkg::OP_DONE && out_free) begin
            r_out_voltage <= r_volt;
            r_out_weight <= r_perm;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.voltage = r_out_voltage;
    assign o_res.weight = r_out_weight;

`ifndef ASSERT_OFF
    a_div_rem_below_tc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.op == stdp_pkg::OP_DIV_STEP && !r_div_sat) |-> (r_rem < tc))
        else $error("divider remainder not below time constant");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(ctrl.op == stdp_pkg::OP_DONE))
        else $error("result valid without a completed program");

    a_release_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.op == stdp_pkg::OP_RELEASE) |=> (r_cleft <= $past(r_cleft)))
        else $error("cleft level grew on release");

    a_depress_lowers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.op == stdp_pkg::OP_APPLY && r_cmd == stdp_pkg::CMD_PRE) |=>
        (r_perm <= $past(r_perm)))
        else $error("permeability rose on a pre spike");
`endif

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT = 400_000;
    localparam int TAIL_CYCLES = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int RAND_PHASES = 12;
    localparam int ITEMS_PER_PHASE = 119;
    localparam int HOLD_PHASE = 5;
    localparam int PAUSE_PHASE = 7;
    localparam int REPORT_LIMIT = 10;

    // fixed-point constants of the synapse arithmetic
    localparam logic [63:0] LN2_Q32_C = 64'd2977044472;
    localparam logic [63:0] LOG2E_Q16_C = 64'd94548;
    localparam logic [63:0] EXP_ARG_CAP = 64'd64 << 16;
    localparam logic [63:0] EXP_ZERO_SHIFT = 64'd17;
    localparam logic [63:0] ONE_Q16_C = 64'd65536;
    localparam logic [31:0] DEPRESS_DIV = 32'd10;
    localparam logic [31:0] POTENTIATE_DIV = 32'd20;

    // stimulus steering on permeability
    localparam logic [23:0] LOW_PERM = 24'h040000;
    localparam logic [23:0] HIGH_PERM = 24'h800000;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] at_ms;
        logic [23:0] voltage;
        logic [23:0] weight;
    } t_synapse_out;

    class synapse_mirror;
        logic [16:0] exp_lut [stdp_pkg::EXP_TABLE_DEPTH];
        logic [15:0] rate;
        logic [15:0] decay;
        logic [15:0] len;
        logic [23:0] cleft;
        logic [23:0] perm;
        logic [31:0] last_pre;
        logic [31:0] last_post;
        t_synapse_out pending_outputs[$];
        int failures;
        int mismatches;

        function new();
            logic [63:0] a;
            logic [63:0] term;
            logic [63:0] sum;
            // 2^(-i/DEPTH) via truncating Taylor series of exp in Q32
            for (int i = 0; i < stdp_pkg::EXP_TABLE_DEPTH; i++) begin
                a = (64'(i) * LN2_Q32_C + 64'(stdp_pkg::EXP_TABLE_DEPTH / 2)) /
                    64'(stdp_pkg::EXP_TABLE_DEPTH);
                term = 64'd1 << 32;
                sum = term;
                for (int k = 1; k <= 16; k++) begin
                    term = ((term * a) >> 32) / 64'(k);
                    if (k % 2 == 1) begin
                        sum = (sum >= term) ? sum - term : 64'd0;
                    end else begin
                        sum = sum + term;
                    end
                end
                exp_lut[i] = 17'((sum + 64'd32768) >> 16);
            end
            rate = 16'd655;
            decay = 16'd10;
            len = 16'd65535;
            cleft = '0;
            perm = 24'h010000;
            last_pre = '0;
            last_post = 32'd1;
            failures = 0;
            mismatches = 0;
        endfunction

        function logic [63:0] exp_neg_q16(logic [63:0] x);
            logic [63:0] y;
            logic [63:0] idx;
            if (x > EXP_ARG_CAP) x = EXP_ARG_CAP;
            y = (x * LOG2E_Q16_C + 64'd32768) >> 16;
            if ((y >> 16) >= EXP_ZERO_SHIFT) return '0;
            idx = ((y & 64'hFFFF) * 64'(stdp_pkg::EXP_TABLE_DEPTH)) >> 16;
            return 64'(exp_lut[idx]) >> (y >> 16);
        endfunction

        function logic [63:0] plastic_step(logic [31:0] k);
            logic [63:0] scaled;
            scaled = (64'(rate) * 64'(perm)) >> 16;
            return (scaled * exp_neg_q16(64'(k) << 16)) >> 16;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                stdp_pkg::REG_LEARNING_RATE: rate = data;
                stdp_pkg::REG_DECAY_TIME:    decay = data;
                stdp_pkg::REG_LENGTH_FACTOR: len = data;
                default: ;
            endcase
        endfunction

        function void note_event(logic [1:0] cmd, logic [31:0] at_ms, logic [23:0] amt);
            t_synapse_out e;
            logic [31:0] lag;
            logic [31:0] k;
            logic [63:0] sum;
            logic [63:0] delta;
            logic [63:0] x;
            logic [63:0] bound;
            logic [63:0] rel;
            logic [63:0] v;
            e.cmd = cmd;
            e.at_ms = at_ms;
            e.voltage = '0;
            case (cmd)
                stdp_pkg::CMD_PRE: begin
                    lag = last_post - at_ms;
                    k = '0;
                    sum = 64'(cleft) + 64'(amt);
                    last_pre = at_ms;
                    cleft = (sum > 64'(stdp_pkg::MAX24)) ? stdp_pkg::MAX24 : sum[23:0];
                    // post before or at this pre: depress; otherwise exponent clamps to 0
                    if (lag == 0 || lag[31]) k = (32'd0 - lag) / DEPRESS_DIV;
                    delta = plastic_step(k);
                    perm = (64'(perm) > delta) ? perm - delta[23:0] : '0;
                end
                stdp_pkg::CMD_POST: begin
                    lag = at_ms - last_pre;
                    k = lag[31] ? 32'd0 : lag / POTENTIATE_DIV;
                    sum = 64'(perm) + plastic_step(k);
                    perm = (sum > 64'(stdp_pkg::MAX24)) ? stdp_pkg::MAX24 : sum[23:0];
                    last_post = at_ms;
                end
                stdp_pkg::CMD_READ: begin
                    lag = at_ms - last_pre;
                    if (lag != 0 && !lag[31]) begin
                        x = (64'(lag) << 16) / ((decay == 0) ? 64'd1 : 64'(decay));
                        bound = ONE_Q16_C - exp_neg_q16(x);
                        rel = (64'(cleft) * bound) >> 16;
                        if (rel > 64'(cleft)) rel = 64'(cleft);
                        cleft = cleft - rel[23:0];
                        v = (rel * 64'(perm)) >> 16;
                        v = (v * 64'(len)) >> 16;
                        e.voltage = (v > 64'(stdp_pkg::MAX24)) ? stdp_pkg::MAX24 : v[23:0];
                    end
                end
                default: ;
            endcase
            e.weight = perm;
            pending_outputs.push_back(e);
        endfunction

        function void check_output(logic [23:0] voltage, logic [23:0] weight);
            t_synapse_out e;
            if (pending_outputs.size() == 0) begin
                failures++;
                if (mismatches < REPORT_LIMIT)
                    $display("unexpected output: voltage %06h weight %06h", voltage, weight);
                mismatches++;
                return;
            end
            e = pending_outputs.pop_front();
            if (voltage !== e.voltage || weight !== e.weight) begin
                failures++;
                if (mismatches < REPORT_LIMIT)
                    $display("mismatch cmd %0d t %08h: voltage exp %06h got %06h, weight exp %06h got %06h",
                             e.cmd, e.at_ms, e.voltage, voltage, e.weight, weight);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return pending_outputs.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic quiet;
    logic hold_req;
    logic [31:0] now_ms;
    int cycle_count;

    synapse_mirror sb = new();

    stdp_evt_if evt_ch();
    stdp_cfg_if cfg_ch();
    stdp_res_if res_ch();

    stdp_synapse_update dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("[stdp_synapse_update] ERROR");
                $finish;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            sb.check_output(res_ch.voltage, res_ch.weight);
    end

    // result side back-pressure
    initial begin
        res_ch.ready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                repeat (quiet ? 1 : $urandom_range(1, 25)) @(posedge i_clk);
            end
        end
    end

    task automatic send_event(logic [1:0] cmd, logic [31:0] at_ms, logic [23:0] amt);
        evt_ch.valid <= 1'b1;
        evt_ch.command <= cmd;
        evt_ch.time_ms <= at_ms;
        evt_ch.transmitter_amount <= amt;
        do @(posedge i_clk); while (!evt_ch.ready);
        sb.note_event(cmd, at_ms, amt);
    endtask

    task automatic evt_pause();
        if (!quiet && $urandom_range(0, 3) == 0) begin
            evt_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    task automatic drain_events();
        evt_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.outstanding() != 0);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.write_reg(idx, data);
    endtask

    task automatic write_all(logic [15:0] rate, logic [15:0] decay, logic [15:0] len);
        write_reg(stdp_pkg::REG_LEARNING_RATE, rate);
        write_reg(stdp_pkg::REG_DECAY_TIME, decay);
        write_reg(stdp_pkg::REG_LENGTH_FACTOR, len);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_q16();
        case ($urandom_range(0, 3))
            0: return 16'd0;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic random_event();
        logic [1:0] cmd;
        logic [23:0] amt;
        int r;
        // mostly short steps so spike lags land inside the exponential window
        r = $urandom_range(0, 99);
        if (r < 60) now_ms += $urandom_range(1, 30);
        else if (r < 75) now_ms += $urandom_range(31, 300);
        else if (r < 83) now_ms -= $urandom_range(1, 60);
        else if (r < 90) now_ms = $urandom();
        r = $urandom_range(0, 99);
        // keep permeability away from the tiny values where updates vanish
        if (sb.perm < LOW_PERM)
            cmd = (r < 60) ? stdp_pkg::CMD_POST :
                  (r < 95) ? stdp_pkg::CMD_READ : CMD_UNUSED;
        else if (sb.perm > HIGH_PERM)
            cmd = (r < 55) ? stdp_pkg::CMD_PRE : (r < 70) ? stdp_pkg::CMD_POST :
                  (r < 95) ? stdp_pkg::CMD_READ : CMD_UNUSED;
        else
            cmd = (r < 35) ? stdp_pkg::CMD_PRE : (r < 70) ? stdp_pkg::CMD_POST :
                  (r < 95) ? stdp_pkg::CMD_READ : CMD_UNUSED;
        r = $urandom_range(0, 19);
        if (r < 10) amt = 24'($urandom_range(0, 65535));
        else if (r < 17) amt = 24'($urandom());
        else if (r < 19) amt = stdp_pkg::MAX24;
        else amt = '0;
        send_event(cmd, now_ms, amt);
    endtask

    initial begin
        logic [15:0] rate_w;
        logic [15:0] decay_w;
        logic [15:0] len_w;
        quiet = 1'b0;
        hold_req = 1'b0;
        now_ms = 32'hFFFF_FFC0;
        i_rst_n <= 1'b0;
        evt_ch.valid <= 1'b0;
        evt_ch.command <= stdp_pkg::CMD_PRE;
        evt_ch.time_ms <= '0;
        evt_ch.transmitter_amount <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= stdp_pkg::REG_LEARNING_RATE;
        cfg_ch.data <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: empty cleft, same-time and backwards reads, clamped exponents
        send_event(stdp_pkg::CMD_READ, 32'd0, '0);
        send_event(stdp_pkg::CMD_PRE, 32'd5, stdp_pkg::MAX24);
        send_event(stdp_pkg::CMD_PRE, 32'd5, stdp_pkg::MAX24);
        send_event(stdp_pkg::CMD_READ, 32'd5, '0);
        send_event(stdp_pkg::CMD_READ, 32'd3, '0);
        send_event(stdp_pkg::CMD_POST, 32'd5, '0);
        send_event(stdp_pkg::CMD_POST, 32'd2, stdp_pkg::MAX24);
        send_event(stdp_pkg::CMD_PRE, 32'd1, '0);
        send_event(stdp_pkg::CMD_READ, 32'd30, '0);
        send_event(CMD_UNUSED, 32'hFFFF_FFFF, stdp_pkg::MAX24);
        send_event(stdp_pkg::CMD_READ, 32'd1, '0);
        drain_events();

        // full rate drives permeability to saturation, zero time constant, voltage clips
        write_reg(REG_UNUSED, 16'hFFFF);
        write_all(16'hFFFF, 16'd0, 16'hFFFF);
        repeat (9) send_event(stdp_pkg::CMD_POST, 32'd1, '0);
        send_event(stdp_pkg::CMD_PRE, 32'd1000, stdp_pkg::MAX24);
        send_event(stdp_pkg::CMD_READ, 32'd1001, '0);
        drain_events();

        // wrap of the millisecond counter and the largest positive read lag
        write_all(16'd0, 16'hFFFF, 16'd0);
        send_event(stdp_pkg::CMD_PRE, 32'hFFFF_FFF0, 24'd1);
        send_event(stdp_pkg::CMD_POST, 32'd5, '0);
        send_event(stdp_pkg::CMD_READ, 32'h7FFF_FFEF, '0);

        for (int p = 0; p < RAND_PHASES; p++) begin
            drain_events();
            quiet = (p >= RAND_PHASES - 2);
            case (p)
                0: begin rate_w = 16'd655;   decay_w = 16'd10;    len_w = 16'hFFFF; end
                1: begin rate_w = 16'hFFFF;  decay_w = 16'd1;     len_w = 16'hFFFF; end
                2: begin rate_w = 16'd0;     decay_w = 16'hFFFF;  len_w = 16'd0;    end
                3: begin rate_w = 16'h8000;  decay_w = 16'd0;     len_w = 16'h8000; end
                default: begin
                    rate_w = pick_q16();
                    len_w = pick_q16();
                    case ($urandom_range(0, 4))
                        0: decay_w = 16'd0;
                        1: decay_w = 16'd1;
                        2: decay_w = 16'hFFFF;
                        3: decay_w = 16'($urandom_range(2, 64));
                        default: decay_w = 16'($urandom_range(0, 65535));
                    endcase
                end
            endcase
            write_all(rate_w, decay_w, len_w);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == HOLD_PHASE && n == 10) hold_req = 1'b1;
                if (p == PAUSE_PHASE && n == 60) drain_events();
                random_event();
                evt_pause();
            end
        end

        drain_events();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.failures == 0 && sb.outstanding() == 0) begin
            $display("[stdp_synapse_update] OK");
        end else begin
            $display("[stdp_synapse_update] ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/stdp_pkg.sv
rtl/core/stdp_ifs.sv
rtl/core/stdp_useq.sv
rtl/core/stdp_synapse_update.sv
tb/sv/tb_top.sv
